// ----- rtl/hrd_pkg.sv -----
// Package for the HiSLIP receive deframer: shared types, protocol constants
// and the queue sizing. It depends on nothing else.
package hrd_pkg;

   // HiSLIP prologue and header layout.
   localparam logic [7:0] PROLOGUE_H      = 8'h48;
   localparam logic [7:0] PROLOGUE_S      = 8'h53;
   localparam int         HEADER_SIZE     = 16;
   localparam int         HDR_IDX_W       = $clog2(HEADER_SIZE);
   localparam logic [HDR_IDX_W-1:0] HDR_IDX_TYPE = HDR_IDX_W'(2);
   localparam logic [HDR_IDX_W-1:0] HDR_IDX_LAST = HDR_IDX_W'(HEADER_SIZE - 1);

   // Message type codes that the deframer acts on.
   localparam logic [7:0] MSG_FATAL_ERROR = 8'd2;
   localparam logic [7:0] MSG_ERROR       = 8'd3;
   localparam logic [7:0] MSG_DATA        = 8'd6;
   localparam logic [7:0] MSG_DATA_END    = 8'd7;

   // Input action codes.
   localparam logic ACT_START = 1'b0;
   localparam logic ACT_BYTE  = 1'b1;

   // Status codes reported with the end of a read.
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_TRUNCATED = 2'd1;
   localparam logic [1:0] ST_ERROR_MSG = 2'd2;
   localparam logic [1:0] ST_BAD_PROLOG = 2'd3;

   // Depth of the queue between the front and the back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      KIND_DATA = 2'd0,
      KIND_END  = 2'd1,
      KIND_SKIP = 2'd2,
      KIND_ERR  = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      PH_IDLE    = 3'b001,
      PH_HEADER  = 3'b010,
      PH_PAYLOAD = 3'b100
   } phase_type;

   // One classified item as it travels through the queue.
   typedef struct packed {
      logic        is_start;
      logic [31:0] read_limit;
      logic [7:0]  rx_byte;
      logic        is_h;
      logic        is_s;
      kind_type    byte_kind;
   } item_type;

   // Queue status seen by the front and the back.
   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

// ----- rtl/hrd_req_if.sv -----
// Request channel of the HiSLIP receive deframer: valid/ready and the item.
// Stands alone; no package needed.
interface hrd_req_if;
   logic        valid;
   logic        ready;
   logic        action;
   logic [31:0] read_limit;
   logic [7:0]  rx_byte;

   modport source (output valid, output action, output read_limit, output rx_byte,
                   input ready);
   modport sink   (input valid, input action, input read_limit, input rx_byte,
                   output ready);
endinterface

// ----- rtl/hrd_rsp_if.sv -----
// Response channel of the HiSLIP receive deframer: valid/ready and the result.
// Stands alone; no package needed.
interface hrd_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic        byte_valid;
   logic        done_res;
   logic [1:0]  status;
   logic [31:0] total_bytes;

   modport source (output valid, output out_byte, output byte_valid, output done_res,
                   output status, output total_bytes, input ready);
   modport sink   (input valid, input out_byte, input byte_valid, input done_res,
                   input status, input total_bytes, output ready);
endinterface

// ----- rtl/hrd_front.sv -----
// Front part of the deframer: accepts request items and classifies each byte.
// Depends on hrd_pkg and hrd_req_if.
module hrd_front
   import hrd_pkg::*;
(
   hrd_req_if.sink  req_chan,
   input  qstat_type qstat,
   output logic     push_valid,
   output item_type push_item
);

   kind_type kind;

   // Byte class by message type, used only if the byte lands on the type slot.
   always_comb begin
      case (req_chan.rx_byte)
         MSG_DATA:        kind = KIND_DATA;
         MSG_DATA_END:    kind = KIND_END;
         MSG_ERROR:       kind = KIND_ERR;
         MSG_FATAL_ERROR: kind = KIND_ERR;
         default:         kind = KIND_SKIP;
      endcase
   end

   assign req_chan.ready = !qstat.full;
   assign push_valid     = req_chan.valid && !qstat.full;

   assign push_item.is_start   = (req_chan.action == ACT_START);
   assign push_item.read_limit = req_chan.read_limit;
   assign push_item.rx_byte    = req_chan.rx_byte;
   assign push_item.is_h       = (req_chan.rx_byte == PROLOGUE_H);
   assign push_item.is_s       = (req_chan.rx_byte == PROLOGUE_S);
   assign push_item.byte_kind  = kind;

endmodule

// ----- rtl/hrd_queue.sv -----
// Short queue between the front and the back of the deframer.
// Depends on hrd_pkg.
module hrd_queue
   import hrd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   input  item_type  push_item,
   input  logic      pop,
   output qstat_type qstat,
   output item_type  head_item
);

   item_type              mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     wptr_ff, wptr_in;
   logic [QPTR_W-1:0]     rptr_ff, rptr_in;
   logic [QCNT_W-1:0]     count_ff, count_in;
   logic                  do_push, do_pop;

   assign qstat.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign qstat.empty = (count_ff == '0);
   assign do_push     = push_valid && !qstat.full;
   assign do_pop      = pop && !qstat.empty;
   assign head_item   = mem_ff[rptr_ff];

   always_comb begin
      wptr_in  = do_push ? QPTR_W'(wptr_ff + 1'b1) : wptr_ff;
      rptr_in  = do_pop  ? QPTR_W'(rptr_ff + 1'b1) : rptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = QCNT_W'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = QCNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wptr_ff] <= push_item;
      end
   end

endmodule

// ----- rtl/hrd_back.sv -----
// Back part of the deframer: message parser state and the result register.
// Depends on hrd_pkg and hrd_rsp_if.
module hrd_back
   import hrd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  qstat_type qstat,
   input  item_type  head_item,
   output logic      pop,
   hrd_rsp_if.source rsp_chan
);

   phase_type              phase_ff, phase_in;
   logic [HDR_IDX_W-1:0]   hidx_ff, hidx_in;
   kind_type               kind_ff, kind_in;
   logic [63:0]            remain_ff, remain_in;
   logic [31:0]            count_ff, count_in;
   logic [31:0]            limit_ff, limit_in;
   logic                   trunc_ff, trunc_in;

   logic                   out_valid_ff, out_valid_in;
   logic [7:0]             out_byte_ff, out_byte_in;
   logic                   byte_valid_ff, byte_valid_in;
   logic                   done_ff, done_in;
   logic [1:0]             status_ff, status_in;
   logic [31:0]            total_ff, total_in;

   logic                   advance;
   logic                   emit_byte, emit_done, msg_end;
   logic [1:0]             emit_status;
   logic [63:0]            remain_next;

   assign advance = !out_valid_ff || rsp_chan.ready;
   assign pop     = advance && !qstat.empty;

   always_comb begin
      phase_in    = phase_ff;
      hidx_in     = hidx_ff;
      kind_in     = kind_ff;
      remain_in   = remain_ff;
      count_in    = count_ff;
      limit_in    = limit_ff;
      trunc_in    = trunc_ff;
      emit_byte   = 1'b0;
      emit_done   = 1'b0;
      emit_status = ST_OK;
      msg_end     = 1'b0;
      remain_next = remain_ff;

      if (pop) begin
         if (head_item.is_start) begin
            phase_in  = PH_HEADER;
            hidx_in   = '0;
            kind_in   = KIND_DATA;
            remain_in = '0;
            count_in  = '0;
            limit_in  = head_item.read_limit;
            trunc_in  = 1'b0;
         end else begin
            case (phase_ff)
               PH_HEADER: begin
                  if ((hidx_ff == '0 && !head_item.is_h) ||
                      (hidx_ff == HDR_IDX_W'(1) && !head_item.is_s)) begin
                     emit_done   = 1'b1;
                     emit_status = ST_BAD_PROLOG;
                     phase_in    = PH_IDLE;
                  end else begin
                     if (hidx_ff == HDR_IDX_TYPE) begin
                        kind_in = head_item.byte_kind;
                     end
                     // Bytes 8 to 15 carry the big-endian payload length.
                     if (hidx_ff[HDR_IDX_W-1]) begin
                        remain_next = {remain_ff[55:0], head_item.rx_byte};
                     end
                     remain_in = remain_next;
                     if (hidx_ff == HDR_IDX_LAST) begin
                        if (remain_next == '0) begin
                           msg_end = 1'b1;
                        end else begin
                           phase_in = PH_PAYLOAD;
                        end
                     end else begin
                        hidx_in = HDR_IDX_W'(hidx_ff + 1'b1);
                     end
                  end
               end
               PH_PAYLOAD: begin
                  if (kind_ff == KIND_DATA || kind_ff == KIND_END) begin
                     if (count_ff < limit_ff) begin
                        emit_byte = 1'b1;
                        count_in  = 32'(count_ff + 1'b1);
                     end else begin
                        trunc_in = 1'b1;
                     end
                  end
                  remain_in = 64'(remain_ff - 1'b1);
                  msg_end   = (remain_ff == 64'd1);
               end
               default: begin
               end
            endcase

            // End of one message: error and DataEnd close the read.
            if (msg_end) begin
               case (kind_ff)
                  KIND_ERR: begin
                     emit_done   = 1'b1;
                     emit_status = ST_ERROR_MSG;
                     phase_in    = PH_IDLE;
                  end
                  KIND_END: begin
                     emit_done   = 1'b1;
                     emit_status = trunc_in ? ST_TRUNCATED : ST_OK;
                     phase_in    = PH_IDLE;
                  end
                  default: begin
                     phase_in = PH_HEADER;
                     hidx_in  = '0;
                  end
               endcase
            end
         end
      end

      out_valid_in  = out_valid_ff && !rsp_chan.ready;
      out_byte_in   = out_byte_ff;
      byte_valid_in = byte_valid_ff;
      done_in       = done_ff;
      status_in     = status_ff;
      total_in      = total_ff;
      if (pop) begin
         out_valid_in  = emit_byte || emit_done;
         out_byte_in   = emit_byte ? head_item.rx_byte : 8'd0;
         byte_valid_in = emit_byte;
         done_in       = emit_done;
         status_in     = emit_done ? emit_status : ST_OK;
         total_in      = count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         hidx_ff      <= '0;
         kind_ff      <= KIND_DATA;
         remain_ff    <= '0;
         count_ff     <= '0;
         limit_ff     <= '0;
         trunc_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         hidx_ff      <= hidx_in;
         kind_ff      <= kind_in;
         remain_ff    <= remain_in;
         count_ff     <= count_in;
         limit_ff     <= limit_in;
         trunc_ff     <= trunc_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff   <= out_byte_in;
      byte_valid_ff <= byte_valid_in;
      done_ff       <= done_in;
      status_ff     <= status_in;
      total_ff      <= total_in;
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.out_byte    = out_byte_ff;
   assign rsp_chan.byte_valid  = byte_valid_ff;
   assign rsp_chan.done_res    = done_ff;
   assign rsp_chan.status      = status_ff;
   assign rsp_chan.total_bytes = total_ff;

endmodule

// ----- rtl/hislip_receive_deframer.sv -----
// HiSLIP receive deframer. A start item (action 0) arms a read with a byte
// limit; every following byte item (action 1) is parsed as part of a stream
// of HiSLIP messages with a 16-byte header. Payload bytes of Data and DataEnd
// messages come out one per result item until the limit is used up, after
// which they are dropped and the read is marked truncated. The read ends with
// a result whose done_res is set: after a DataEnd payload (status ok or
// truncated), after an Error or FatalError payload (status error), or at once
// on a bad prologue byte. The block takes one item every clock cycle while
// the queue is not full. An accepted item goes into a four-entry queue. The
// parser pops one item a cycle from it when it is not stalled and loads the
// result into the result register, so each result passes through the queue
// and then the result register before the sink can take it. The parser stalls
// only while the result register holds an item the sink has not taken; the
// queue then keeps taking up to four more items before req ready drops.
// Depends on hrd_pkg, hrd_req_if, hrd_rsp_if, hrd_front, hrd_queue, hrd_back.
module hislip_receive_deframer
   import hrd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   hrd_req_if.sink   req_chan,
   hrd_rsp_if.source rsp_chan
);

   qstat_type qstat;
   logic      push_valid;
   item_type  push_item;
   item_type  head_item;
   logic      pop;

   // Front: handshake with the source and byte classification.
   hrd_front u_front (
      .req_chan   (req_chan),
      .qstat      (qstat),
      .push_valid (push_valid),
      .push_item  (push_item)
   );

   // Queue that lets the front keep accepting while the back is stalled.
   hrd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .pop        (pop),
      .qstat      (qstat),
      .head_item  (head_item)
   );

   // Back: message parser and the result register.
   hrd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .qstat     (qstat),
      .head_item (head_item),
      .pop       (pop),
      .rsp_chan  (rsp_chan)
   );

endmodule

// ----- rtl/hrd_checker.sv -----
// Port-level checks for the HiSLIP receive deframer and the bind that
// attaches them to the top level. Depends on hrd_pkg and the top level.
module hrd_checker
   import hrd_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  out_byte,
   input logic        byte_valid,
   input logic        done_res,
   input logic [1:0]  status,
   input logic [31:0] total_bytes
);

   // A stalled result keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_byte) &&
      $stable(byte_valid) && $stable(done_res) && $stable(status) &&
      $stable(total_bytes))
      else $error("response changed while stalled");

   // Every result carries a byte or ends the read.
   a_no_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> byte_valid || done_res)
      else $error("empty result item");

   // Status is only nonzero at the end of a read.
   a_status_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !done_res |-> status == ST_OK)
      else $error("status set without done");

   // A delivered byte means at least one byte counted in this read.
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && byte_valid |-> total_bytes != 32'd0)
      else $error("byte delivered with zero total");

endmodule

bind hislip_receive_deframer hrd_checker u_hrd_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .out_byte    (rsp_chan.out_byte),
   .byte_valid  (rsp_chan.byte_valid),
   .done_res    (rsp_chan.done_res),
   .status      (rsp_chan.status),
   .total_bytes (rsp_chan.total_bytes)
);
